// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; each expects clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHECK_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/phc_pkg.sv =====
package phc_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE_MIN = 3'd0,
        MODE_IDLE     = 3'd1,
        MODE_PUMP_MIN = 3'd2,
        MODE_PUMPING  = 3'd3,
        MODE_CLEANING = 3'd4
    } mode_t;

    typedef struct packed {
        logic  pump_on;
        mode_t mode;
    } status_t;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_MIN_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_MAX_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_MIN_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_MAX_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_ON       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_OFF      = 3'd5;

    // Register reset values, truncated to the configured widths where used
    localparam int RST_IDLE_MIN_TICKS = 60;
    localparam int RST_IDLE_MAX_TICKS = 1440;
    localparam int RST_PUMP_MIN_TICKS = 5;
    localparam int RST_PUMP_MAX_TICKS = 600;
    localparam int RST_DELTA_ON       = 8;
    localparam int RST_DELTA_OFF      = 7;

endpackage

// ===== hw/rtl/phc_cfg.sv =====
module phc_cfg #(
    parameter int TIMER_BITS = 20,
    parameter int TEMP_BITS  = 8,
    parameter int CFG_W      = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [phc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    output logic [TIMER_BITS-1:0]         idle_min_ticks,
    output logic [TIMER_BITS-1:0]         idle_max_ticks,
    output logic [TIMER_BITS-1:0]         pump_min_ticks,
    output logic [TIMER_BITS-1:0]         pump_max_ticks,
    output logic signed [TEMP_BITS-1:0]   delta_on,
    output logic signed [TEMP_BITS-1:0]   delta_off
);
    import phc_pkg::*;

    logic [TIMER_BITS-1:0]       idle_min_reg;
    logic [TIMER_BITS-1:0]       idle_max_reg;
    logic [TIMER_BITS-1:0]       pump_min_reg;
    logic [TIMER_BITS-1:0]       pump_max_reg;
    logic signed [TEMP_BITS-1:0] delta_on_reg;
    logic signed [TEMP_BITS-1:0] delta_off_reg;

    // Out-of-range indexes fall through and are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_min_reg  <= TIMER_BITS'(RST_IDLE_MIN_TICKS);
            idle_max_reg  <= TIMER_BITS'(RST_IDLE_MAX_TICKS);
            pump_min_reg  <= TIMER_BITS'(RST_PUMP_MIN_TICKS);
            pump_max_reg  <= TIMER_BITS'(RST_PUMP_MAX_TICKS);
            delta_on_reg  <= TEMP_BITS'(RST_DELTA_ON);
            delta_off_reg <= TEMP_BITS'(RST_DELTA_OFF);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_IDLE_MIN_TICKS: idle_min_reg  <= cfg_data[TIMER_BITS-1:0];
                CFG_IDLE_MAX_TICKS: idle_max_reg  <= cfg_data[TIMER_BITS-1:0];
                CFG_PUMP_MIN_TICKS: pump_min_reg  <= cfg_data[TIMER_BITS-1:0];
                CFG_PUMP_MAX_TICKS: pump_max_reg  <= cfg_data[TIMER_BITS-1:0];
                CFG_DELTA_ON:       delta_on_reg  <= cfg_data[TEMP_BITS-1:0];
                CFG_DELTA_OFF:      delta_off_reg <= cfg_data[TEMP_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign idle_min_ticks = idle_min_reg;
    assign idle_max_ticks = idle_max_reg;
    assign pump_min_ticks = pump_min_reg;
    assign pump_max_ticks = pump_max_reg;
    assign delta_on       = delta_on_reg;
    assign delta_off      = delta_off_reg;

endmodule

// ===== hw/rtl/phc_step.sv =====
module phc_step #(
    parameter int TIMER_BITS = 20,
    parameter int TEMP_BITS  = 8
) (
    input  phc_pkg::status_t            cur,
    input  logic [TIMER_BITS-1:0]       remaining,
    input  logic                        tick,
    input  logic                        toggle_request,
    input  logic signed [TEMP_BITS-1:0] temp_delta,
    input  logic [TIMER_BITS-1:0]       idle_min_ticks,
    input  logic [TIMER_BITS-1:0]       idle_max_ticks,
    input  logic [TIMER_BITS-1:0]       pump_min_ticks,
    input  logic [TIMER_BITS-1:0]       pump_max_ticks,
    input  logic signed [TEMP_BITS-1:0] delta_on,
    input  logic signed [TEMP_BITS-1:0] delta_off,
    output phc_pkg::status_t            nxt,
    output logic [TIMER_BITS-1:0]       remaining_next
);
    import phc_pkg::*;

    status_t               st_dec;
    status_t               st_tog;
    logic [TIMER_BITS-1:0] rem_dec;
    logic [TIMER_BITS-1:0] rem_tog;
    logic                  alarm;
    logic                  rule_fire;
    mode_t                 rule_target;

    function automatic logic [TIMER_BITS-1:0] mode_len(input mode_t m);
        case (m)
            MODE_IDLE_MIN: mode_len = idle_min_ticks;
            MODE_IDLE:     mode_len = idle_max_ticks;
            MODE_PUMP_MIN: mode_len = pump_min_ticks;
            default:       mode_len = pump_max_ticks;
        endcase
    endfunction

    // Idle and pumping keep whatever drive they had
    function automatic logic mode_pump(input mode_t m, input logic cur_pump);
        case (m)
            MODE_IDLE_MIN: mode_pump = 1'b0;
            MODE_PUMP_MIN: mode_pump = 1'b1;
            MODE_CLEANING: mode_pump = 1'b1;
            default:       mode_pump = cur_pump;
        endcase
    endfunction

    // Tick, then toggle
    always_comb
    begin
        st_dec  = cur;
        rem_dec = (tick && (remaining != '0)) ? remaining - 1'b1 : remaining;
        st_tog  = st_dec;
        rem_tog = rem_dec;
        if (toggle_request)
        begin
            st_tog.mode = ((st_dec.mode == MODE_IDLE_MIN) || (st_dec.mode == MODE_IDLE))
                          ? MODE_PUMP_MIN : MODE_IDLE_MIN;
            st_tog.pump_on = mode_pump(st_tog.mode, st_dec.pump_on);
            rem_tog        = mode_len(st_tog.mode);
        end
    end

    // Mode rule, at most one transition
    always_comb
    begin
        alarm       = (rem_tog == '0);
        rule_fire   = 1'b0;
        rule_target = MODE_IDLE_MIN;
        case (st_tog.mode)
            MODE_IDLE_MIN:
            begin
                rule_fire   = alarm;
                rule_target = MODE_IDLE;
            end
            MODE_IDLE:
            begin
                if (temp_delta >= delta_on)
                begin
                    rule_fire   = 1'b1;
                    rule_target = MODE_PUMP_MIN;
                end
                else
                begin
                    rule_fire   = alarm;
                    rule_target = MODE_CLEANING;
                end
            end
            MODE_PUMP_MIN:
            begin
                rule_fire   = alarm;
                rule_target = MODE_PUMPING;
            end
            MODE_PUMPING:
            begin
                rule_fire   = (temp_delta <= delta_off) || alarm;
                rule_target = MODE_IDLE_MIN;
            end
            MODE_CLEANING:
            begin
                rule_fire   = alarm;
                rule_target = MODE_IDLE_MIN;
            end
            default:
            begin
                rule_fire   = 1'b0;
                rule_target = MODE_IDLE_MIN;
            end
        endcase
    end

    always_comb
    begin
        nxt            = st_tog;
        remaining_next = rem_tog;
        if (rule_fire)
        begin
            nxt.mode       = rule_target;
            nxt.pump_on    = mode_pump(rule_target, st_tog.pump_on);
            remaining_next = mode_len(rule_target);
        end
    end

endmodule

// ===== hw/rtl/phc_skid.sv =====
`include "assert_macros.svh"

module phc_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  phc_pkg::status_t push_data,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output phc_pkg::status_t out_data
);
    import phc_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    status_t main_data_reg;
    status_t skid_data_reg;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign room      = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                main_data_reg <= push_data;
            end
        end
    end

    `CHECK_IMPLIES(a_skid_behind_main, skid_valid_reg, main_valid_reg,
        "skid word held with empty output register")
    `CHECK_NEXT(a_skid_fill_on_stall, !skid_valid_reg && push && main_valid_reg && !out_ready,
        skid_valid_reg, "word pushed during stall was not parked")

endmodule

// ===== hw/rtl/pump_hysteresis_controller_top.sv =====
// Solar-heater pump controller, five modes with one countdown timer.
//
// Input channel (in_valid/in_ready): one word per control step carrying tick,
// toggle_request and temp_delta. Output channel (out_valid/out_ready): one
// word per input word with pump_drive and mode_code after that step.
// Config port: cfg_write_en/cfg_index/cfg_data writes one register per cycle;
// indexes beyond the list are dropped. Writes do not reload a running timer.
//
// The result is registered into the output buffer as the input word is taken.
// Throughput: one word per cycle while in_ready is high; the whole step
// (decrement, toggle, mode rule) is a single combinational pass from the
// state registers into the output buffer.
// Stall: a two-entry output buffer (output register plus skid) keeps in_ready
// high while one result waits; in_ready drops only once both are full.
// Reset: mode idle-minimum, pump off, timer loaded with the idle-minimum
// reset length, registers at their reset values, output buffer empty.
`include "assert_macros.svh"

module pump_hysteresis_controller_top #(
    parameter int TIMER_BITS = 20,
    parameter int TEMP_BITS  = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    tick,
    input  logic                                    toggle_request,
    input  logic signed [TEMP_BITS-1:0]             temp_delta,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    pump_drive,
    output logic [2:0]                              mode_code,
    input  logic                                    cfg_write_en,
    input  logic [phc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [((TIMER_BITS > TEMP_BITS) ? TIMER_BITS : TEMP_BITS)-1:0] cfg_data
);
    import phc_pkg::*;

    localparam int CFG_W = (TIMER_BITS > TEMP_BITS) ? TIMER_BITS : TEMP_BITS;

    // Config registers
    logic [TIMER_BITS-1:0]       idle_min_ticks;
    logic [TIMER_BITS-1:0]       idle_max_ticks;
    logic [TIMER_BITS-1:0]       pump_min_ticks;
    logic [TIMER_BITS-1:0]       pump_max_ticks;
    logic signed [TEMP_BITS-1:0] delta_on;
    logic signed [TEMP_BITS-1:0] delta_off;

    // Controller state
    status_t               status_reg;
    status_t               status_next;
    logic [TIMER_BITS-1:0] remaining_reg;
    logic [TIMER_BITS-1:0] remaining_next;

    logic    push;
    logic    room;
    status_t out_data;

    phc_cfg #(
        .TIMER_BITS (TIMER_BITS),
        .TEMP_BITS  (TEMP_BITS),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .idle_min_ticks (idle_min_ticks),
        .idle_max_ticks (idle_max_ticks),
        .pump_min_ticks (pump_min_ticks),
        .pump_max_ticks (pump_max_ticks),
        .delta_on       (delta_on),
        .delta_off      (delta_off)
    );

    // Step logic: decrement, toggle, then the mode rule
    phc_step #(
        .TIMER_BITS (TIMER_BITS),
        .TEMP_BITS  (TEMP_BITS)
    ) u_step (
        .cur            (status_reg),
        .remaining      (remaining_reg),
        .tick           (tick),
        .toggle_request (toggle_request),
        .temp_delta     (temp_delta),
        .idle_min_ticks (idle_min_ticks),
        .idle_max_ticks (idle_max_ticks),
        .pump_min_ticks (pump_min_ticks),
        .pump_max_ticks (pump_max_ticks),
        .delta_on       (delta_on),
        .delta_off      (delta_off),
        .nxt            (status_next),
        .remaining_next (remaining_next)
    );

    assign in_ready = room;
    assign push     = in_valid && room;

    // State advances only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg.mode    <= MODE_IDLE_MIN;
            status_reg.pump_on <= 1'b0;
            remaining_reg      <= TIMER_BITS'(RST_IDLE_MIN_TICKS);
        end
        else if (push)
        begin
            status_reg    <= status_next;
            remaining_reg <= remaining_next;
        end
    end

    phc_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (status_next),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign pump_drive = out_data.pump_on;
    assign mode_code  = out_data.mode;

    `CHECK_IMPLIES(a_pump_on_modes,
        (status_reg.mode == MODE_PUMP_MIN) || (status_reg.mode == MODE_CLEANING),
        status_reg.pump_on, "pump off in a pumping mode")
    `CHECK_IMPLIES(a_pump_off_idle_min, status_reg.mode == MODE_IDLE_MIN,
        !status_reg.pump_on, "pump on in idle-minimum mode")
    `CHECK_NEXT(a_state_holds_idle, !push, $stable(remaining_reg),
        "timer moved without an accepted word")

endmodule
